@@ hw/rtl/gate_round_robin_spreader_assert.svh @@
// ----------------------------------------------------------------------------
// Gate round-robin spreader assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GATE_ROUND_ROBIN_SPREADER_ASSERT_SVH
`define GATE_ROUND_ROBIN_SPREADER_ASSERT_SVH
`ifndef SYNTHESIS
`define GRRS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle implication failed");
`define GRRS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");
`else
`define GRRS_ASSERT_IMPLY(lbl, ante, cons)
`define GRRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/grrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Gate round-robin spreader package
// Shared field widths, trigger thresholds, register indexes and state types.
// ----------------------------------------------------------------------------
package grrs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LANE_W   = 3;
	localparam int SLOT_W   = 4;
	localparam int CH_W     = 4;
	localparam int TOTAL_W  = 5;
	localparam int SEL_W    = 3;
	localparam int ACT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic signed [SAMPLE_W-1:0] TH_LOW  = 16'sd200;
	localparam logic signed [SAMPLE_W-1:0] TH_HIGH = 16'sd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HOLD_MODE     = 2'd0,
		REG_SPREAD_SELECT = 2'd1,
		REG_ACTIVE_LANES  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              high;
		logic [SLOT_W-1:0] slot;
	} lane_state_t;

	typedef struct packed {
		logic        we;
		lane_state_t st;
	} lane_commit_t;

endpackage

@@ hw/rtl/grrs_lane_state.sv @@
// ----------------------------------------------------------------------------
// Gate round-robin spreader lane state
// Per-lane Schmitt state and slot, read by lane and written back on commit.
// ----------------------------------------------------------------------------
module grrs_lane_state
	import grrs_pkg::*;
#(
	parameter int LANES = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clear,
	input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] idx,
	input  lane_commit_t                           commit,
	output lane_state_t                            rd
);

	lane_state_t state_q [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				state_q[i] <= '0;
			end
		end else if (clear) begin
			for (int i = 0; i < LANES; i++) begin
				state_q[i] <= '0;
			end
		end else if (commit.we) begin
			state_q[idx] <= commit.st;
		end
	end

	assign rd = state_q[idx];

endmodule

@@ hw/rtl/gate_round_robin_spreader.sv @@
// ----------------------------------------------------------------------------
// Gate round-robin spreader
// Schmitt-triggers each lane's gate and spreads gate and CV over a block of
// output channels per lane, advancing an active lane's slot on every falling edge.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake           | Beat contents
//   in      | input     | in_valid/in_stall   | lane, gate_sample, cv_sample
//   out     | output    | out_valid/out_stall | gate and CV channel writes
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// One beat is accepted per cycle while in_stall is low; it is registered in the
// compute stage and then in the result register that drives out.
// The rate is set by the lane state read-modify-write in the compute stage.
// Reset and every configuration write to a defined register index clear all lane state.
// A stall on out holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
`include "gate_round_robin_spreader_assert.svh"

module gate_round_robin_spreader
	import grrs_pkg::*;
#(
	parameter int LANES        = 8,
	parameter int OUT_CHANNELS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [LANE_W-1:0]          lane,
	input  logic signed [SAMPLE_W-1:0] gate_sample,
	input  logic signed [SAMPLE_W-1:0] cv_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [CH_W-1:0]            gate_channel,
	output logic                       gate_level,
	output logic                       gate_write,
	output logic [CH_W-1:0]            cv_channel,
	output logic signed [SAMPLE_W-1:0] cv_value,
	output logic                       cv_write,
	output logic [TOTAL_W-1:0]         total_channels,
	output logic                       overflow_error
);

	localparam int IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int LN_W   = $clog2(LANES + 1);
	localparam int SP_MAX = (OUT_CHANNELS > 8) ? OUT_CHANNELS : 8;
	localparam int SP_W   = $clog2(SP_MAX + 1);
	localparam int TOT_W  = SP_W + LN_W;
	localparam int BASE_W = LANE_W + SP_W;

	logic                hold_mode_q;
	logic [SEL_W-1:0]    spread_select_q;
	logic [ACT_W-1:0]    active_lanes_q;
	logic                cfg_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_mode_q     <= 1'b0;
			spread_select_q <= '0;
			active_lanes_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HOLD_MODE:     hold_mode_q     <= cfg_data[0];
				REG_SPREAD_SELECT: spread_select_q <= cfg_data[SEL_W-1:0];
				REG_ACTIVE_LANES:  active_lanes_q  <= cfg_data[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_index)
			REG_HOLD_MODE, REG_SPREAD_SELECT, REG_ACTIVE_LANES: cfg_clear = cfg_write;
			default: cfg_clear = 1'b0;
		endcase
	end

	logic [LN_W-1:0]  lanes_eff;
	logic [SP_W-1:0]  spread_tab [LANES+1];
	logic [SP_W-1:0]  spread;
	logic [TOT_W-1:0] total;
	logic             overflow;

	for (genvar l = 0; l <= LANES; l++) begin : g_spread_tab
		localparam int Q = (l == 0) ? 0 : OUT_CHANNELS / ((l == 0) ? 1 : l);
		assign spread_tab[l] = SP_W'(Q);
	end

	assign lanes_eff = (int'(active_lanes_q) > LANES) ? LN_W'(LANES) : LN_W'(active_lanes_q);
	assign spread    = (spread_select_q == '0) ? spread_tab[lanes_eff]
		: SP_W'(spread_select_q) + SP_W'(1);
	assign total     = TOT_W'(spread) * TOT_W'(lanes_eff);
	assign overflow  = int'(total) > OUT_CHANNELS;

	logic                       valid_s1;
	logic [LANE_W-1:0]          lane_s1;
	logic signed [SAMPLE_W-1:0] gate_s1;
	logic signed [SAMPLE_W-1:0] cv_s1;
	logic                       out_advance;
	logic                       move_s1;

	assign out_advance = !out_valid || !out_stall;
	assign move_s1     = valid_s1 && out_advance;
	assign in_stall    = valid_s1 && !out_advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			lane_s1 <= lane;
			gate_s1 <= gate_sample;
			cv_s1   <= cv_sample;
		end
	end

	logic [IDX_W-1:0]    lane_idx;
	lane_state_t         cur;
	lane_commit_t        commit;
	logic                lane_active;
	logic                now_high;
	logic                rising;
	logic                falling;
	logic [SLOT_W:0]     slot_inc;
	logic [SLOT_W-1:0]   slot_new;
	logic [BASE_W-1:0]   base;
	logic [CH_W-1:0]     gate_ch;
	logic [CH_W-1:0]     cv_ch;
	logic                cv_wr;

	assign lane_idx = IDX_W'(lane_s1);

	grrs_lane_state #(
		.LANES(LANES)
	) u_lane_state (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_clear),
		.idx    (lane_idx),
		.commit (commit),
		.rd     (cur)
	);

	always_comb begin
		lane_active = !overflow && (int'(lane_s1) < int'(lanes_eff))
			&& (int'(lane_s1) < LANES) && (spread != '0);
		if (cur.high) begin
			now_high = !(gate_s1 <= TH_LOW);
			rising   = 1'b0;
		end else begin
			now_high = gate_s1 >= TH_HIGH;
			rising   = now_high;
		end
		falling  = cur.high && !now_high;
		slot_inc = {1'b0, cur.slot} + (SLOT_W+1)'(1);
		if (!falling) begin
			slot_new = cur.slot;
		end else if (int'(slot_inc) == int'(spread)) begin
			slot_new = '0;
		end else begin
			slot_new = slot_inc[SLOT_W-1:0];
		end
		base    = BASE_W'(lane_s1) * BASE_W'(spread);
		gate_ch = CH_W'(base + BASE_W'(cur.slot));
		cv_ch   = CH_W'(base + BASE_W'(slot_new));
		cv_wr   = lane_active && now_high && (rising || hold_mode_q);
		commit.we      = move_s1 && lane_active;
		commit.st.high = now_high;
		commit.st.slot = slot_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			gate_channel   <= lane_active ? gate_ch : '0;
			gate_level     <= lane_active && now_high;
			gate_write     <= lane_active;
			cv_channel     <= cv_wr ? cv_ch : '0;
			cv_value       <= cv_wr ? cv_s1 : '0;
			cv_write       <= cv_wr;
			total_channels <= overflow ? '0 : TOTAL_W'(total);
			overflow_error <= overflow;
		end
	end

	`GRRS_ASSERT_IMPLY(a_overflow_quiet, out_valid && overflow_error,
		!gate_write && !cv_write && (total_channels == '0))
	`GRRS_ASSERT_IMPLY(a_cv_needs_gate_high, out_valid && cv_write, gate_write && gate_level)
	`GRRS_ASSERT_IMPLY(a_slot_below_spread, commit.we, int'(commit.st.slot) < int'(spread))
	`GRRS_ASSERT_IMPLY(a_stall_only_when_full, in_stall, valid_s1 && out_valid && out_stall)
	`GRRS_ASSERT_NEXT(a_commit_reaches_out, commit.we, out_valid && gate_write)

endmodule
